[sv/spmg_pkg.sv]
package spmg_pkg;

  localparam int PW    = 48;
  localparam int MW    = 63;
  localparam int EW    = 40;
  localparam int SW    = 97;
  localparam int XW    = 130;
  localparam int TW    = 64;
  localparam int DW    = 161;
  localparam int NMW   = 111;
  localparam int RW    = 209;
  localparam int QW    = 48;
  localparam int SQ_N  = 64;
  localparam int DIV_N = 48;

  localparam logic [0:0] CFG_MU  = 1'b0;
  localparam logic [0:0] CFG_EPS = 1'b1;

  typedef struct packed {
    logic [2:0][PW-1:0] mag;
    logic [2:0]         neg;
    logic [2:0]         nz;
    logic               z;
  } pay_t;

endpackage

[sv/softened_point_mass_gravity_unit.sv]
// Softened point-mass gravity unit.
// Input channel: in_valid/in_stall with the offset vector from the source to
// the point (offset_x/y/z, signed, LSB 1/16 m). A transfer happens at a clock
// edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall with accel_x/y/z (signed, LSB 2^-24
// m/s^2) and saturated, set when any component was clamped to 48 bits.
// Configuration: cfg_we writes cfg_data to register cfg_index (0: mu,
// 1: softening length). Write only while no item is in flight.
// Throughput: one item per cycle while out_stall does not hold the pipeline.
// Pipeline: 4 stages of magnitude and squaring, 64
// square-root stages (one root bit each), 4 stages of multiply and sum, 48
// restoring division stages (one quotient bit each, three lanes) and the
// output register.
// Reset clears all valid bits and both configuration registers.
// When the receiver stalls a held result, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated.
module softened_point_mass_gravity_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [47:0]  in_offset_x,
  input  logic signed [47:0]  in_offset_y,
  input  logic signed [47:0]  in_offset_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  out_accel_x,
  output logic signed [47:0]  out_accel_y,
  output logic signed [47:0]  out_accel_z,
  output logic                out_saturated,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [62:0]         cfg_data
);

  logic [spmg_pkg::MW-1:0] mu_r;
  logic [spmg_pkg::EW-1:0] eps_r;
  logic                    adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r  <= '0;
      eps_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spmg_pkg::CFG_MU:  mu_r  <= cfg_data;
        spmg_pkg::CFG_EPS: eps_r <= cfg_data[spmg_pkg::EW-1:0];
        default: ;
      endcase
    end
  end

  logic out_v_r;
  assign adv      = !(out_v_r && out_stall);
  assign in_stall = !adv;

  // stage 1: magnitudes
  logic [2:0][47:0] off;
  assign off[0] = in_offset_x;
  assign off[1] = in_offset_y;
  assign off[2] = in_offset_z;

  logic           v1_r;
  spmg_pkg::pay_t pay1_r, pay1_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pay1_nxt.neg[k] = off[k][47];
      pay1_nxt.mag[k] = off[k][47] ? (~off[k] + 48'd1) : off[k];
      pay1_nxt.nz[k]  = (off[k] != '0);
    end
    pay1_nxt.z = !(|pay1_nxt.nz) && (eps_r == '0);
  end

  // stage 2: partial squares
  logic                   v2_r;
  spmg_pkg::pay_t         pay2_r;
  logic [2:0][2:0][47:0]  pp2_r, pp2_nxt;
  logic [2:0][39:0]       ep2_r, ep2_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pp2_nxt[k][0] = pay1_r.mag[k][47:24] * pay1_r.mag[k][47:24];
      pp2_nxt[k][1] = pay1_r.mag[k][47:24] * pay1_r.mag[k][23:0];
      pp2_nxt[k][2] = pay1_r.mag[k][23:0] * pay1_r.mag[k][23:0];
    end
    ep2_nxt[0] = eps_r[39:20] * eps_r[39:20];
    ep2_nxt[1] = eps_r[39:20] * eps_r[19:0];
    ep2_nxt[2] = eps_r[19:0] * eps_r[19:0];
  end

  // stage 3: squares
  logic             v3_r;
  spmg_pkg::pay_t   pay3_r;
  logic [2:0][95:0] sq3_r, sq3_nxt;
  logic [79:0]      e3_r, e3_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq3_nxt[k] = (96'(pp2_r[k][0]) << 48) + (96'(pp2_r[k][1]) << 25) + 96'(pp2_r[k][2]);
    end
    e3_nxt = (80'(ep2_r[0]) << 40) + (80'(ep2_r[1]) << 21) + 80'(ep2_r[2]);
  end

  // stage 4: softened squared distance
  logic                    v4_r;
  spmg_pkg::pay_t          pay4_r;
  logic [spmg_pkg::SW-1:0] s4_r, s4_nxt;

  assign s4_nxt = spmg_pkg::SW'(sq3_r[0]) + spmg_pkg::SW'(sq3_r[1])
                + spmg_pkg::SW'(sq3_r[2]) + spmg_pkg::SW'(e3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay1_r <= pay1_nxt;
      pay2_r <= pay1_r;
      pp2_r  <= pp2_nxt;
      ep2_r  <= ep2_nxt;
      pay3_r <= pay2_r;
      sq3_r  <= sq3_nxt;
      e3_r   <= e3_nxt;
      pay4_r <= pay3_r;
      s4_r   <= s4_nxt;
    end
  end

  // square root of S * 2^32, one bit per stage
  logic                    sq_v_r    [spmg_pkg::SQ_N];
  spmg_pkg::pay_t          sq_pay_r  [spmg_pkg::SQ_N];
  logic [spmg_pkg::SW-1:0] sq_s_r    [spmg_pkg::SQ_N];
  logic [spmg_pkg::XW-1:0] sq_rem_r  [spmg_pkg::SQ_N];
  logic [spmg_pkg::XW-1:0] sq_rem_nxt[spmg_pkg::SQ_N];
  logic [spmg_pkg::TW-1:0] sq_root_r [spmg_pkg::SQ_N];
  logic [spmg_pkg::TW-1:0] sq_root_nxt[spmg_pkg::SQ_N];

  for (genvar i = 0; i < spmg_pkg::SQ_N; i++) begin : g_sq
    localparam int B = spmg_pkg::SQ_N - 1 - i;
    logic                    vin;
    spmg_pkg::pay_t          pin;
    logic [spmg_pkg::SW-1:0] sin;
    logic [spmg_pkg::XW-1:0] rin;
    logic [spmg_pkg::XW-1:0] trial;
    logic [spmg_pkg::TW-1:0] tin;

    if (i == 0) begin : g_src
      assign vin = v4_r;
      assign pin = pay4_r;
      assign sin = s4_r;
      assign rin = spmg_pkg::XW'(s4_r) << 32;
      assign tin = '0;
    end else begin : g_src
      assign vin = sq_v_r[i-1];
      assign pin = sq_pay_r[i-1];
      assign sin = sq_s_r[i-1];
      assign rin = sq_rem_r[i-1];
      assign tin = sq_root_r[i-1];
    end

    assign trial = (spmg_pkg::XW'(tin) << (B + 1)) | (spmg_pkg::XW'(1) << (2 * B));

    always_comb begin
      sq_rem_nxt[i]  = rin;
      sq_root_nxt[i] = tin;
      if (rin >= trial) begin
        sq_rem_nxt[i]  = rin - trial;
        sq_root_nxt[i] = tin | (spmg_pkg::TW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i] <= 1'b0;
      end else if (adv) begin
        sq_v_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_pay_r[i]  <= pin;
        sq_s_r[i]    <= sin;
        sq_rem_r[i]  <= sq_rem_nxt[i];
        sq_root_r[i] <= sq_root_nxt[i];
      end
    end
  end

  // denominator S*T and numerators mu*|p|*2^58
  localparam int SQL = spmg_pkg::SQ_N - 1;

  logic                         m1_v_r;
  spmg_pkg::pay_t               m1_pay_r;
  logic [3:0][1:0][63:0]        m1_dp_r, m1_dp_nxt;
  logic [2:0][1:0][1:0][55:0]   m1_np_r, m1_np_nxt;
  logic [127:0]                 s_ext;

  assign s_ext = 128'(sq_s_r[SQL]);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      m1_dp_nxt[j][0] = s_ext[32*j +: 32] * sq_root_r[SQL][31:0];
      m1_dp_nxt[j][1] = s_ext[32*j +: 32] * sq_root_r[SQL][63:32];
    end
    for (int k = 0; k < 3; k++) begin
      m1_np_nxt[k][0][0] = mu_r[31:0] * sq_pay_r[SQL].mag[k][23:0];
      m1_np_nxt[k][0][1] = mu_r[31:0] * sq_pay_r[SQL].mag[k][47:24];
      m1_np_nxt[k][1][0] = 56'(mu_r[62:32] * sq_pay_r[SQL].mag[k][23:0]);
      m1_np_nxt[k][1][1] = 56'(mu_r[62:32] * sq_pay_r[SQL].mag[k][47:24]);
    end
  end

  logic                                m2_v_r;
  spmg_pkg::pay_t                      m2_pay_r;
  logic [3:0][95:0]                    m2_row_r, m2_row_nxt;
  logic [2:0][spmg_pkg::NMW-1:0]       m2_nm_r, m2_nm_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      m2_row_nxt[j] = 96'(m1_dp_r[j][0]) + (96'(m1_dp_r[j][1]) << 32);
    end
    for (int k = 0; k < 3; k++) begin
      m2_nm_nxt[k] = spmg_pkg::NMW'(m1_np_r[k][0][0])
                   + (spmg_pkg::NMW'(m1_np_r[k][0][1]) << 24)
                   + (spmg_pkg::NMW'(m1_np_r[k][1][0]) << 32)
                   + (spmg_pkg::NMW'(m1_np_r[k][1][1]) << 56);
    end
  end

  logic                          m3_v_r;
  spmg_pkg::pay_t                m3_pay_r;
  logic [spmg_pkg::DW-1:0]       m3_den_r, m3_den_nxt;
  logic [2:0][spmg_pkg::RW-1:0]  m3_num_r, m3_num_nxt;

  always_comb begin
    m3_den_nxt = spmg_pkg::DW'(m2_row_r[0]) + (spmg_pkg::DW'(m2_row_r[1]) << 32)
               + (spmg_pkg::DW'(m2_row_r[2]) << 64) + (spmg_pkg::DW'(m2_row_r[3]) << 96);
    for (int k = 0; k < 3; k++) begin
      m3_num_nxt[k] = spmg_pkg::RW'(m2_nm_r[k]) << 58;
    end
  end

  logic                          m4_v_r;
  spmg_pkg::pay_t                m4_pay_r;
  logic [spmg_pkg::DW-1:0]       m4_den_r;
  logic [2:0][spmg_pkg::RW-1:0]  m4_num_r;
  logic [2:0]                    m4_ovf_r, m4_ovf_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m4_ovf_nxt[k] = m3_num_r[k] >= (spmg_pkg::RW'(m3_den_r) << spmg_pkg::QW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
    end else if (adv) begin
      m1_v_r <= sq_v_r[SQL];
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_pay_r <= sq_pay_r[SQL];
      m1_dp_r  <= m1_dp_nxt;
      m1_np_r  <= m1_np_nxt;
      m2_pay_r <= m1_pay_r;
      m2_row_r <= m2_row_nxt;
      m2_nm_r  <= m2_nm_nxt;
      m3_pay_r <= m2_pay_r;
      m3_den_r <= m3_den_nxt;
      m3_num_r <= m3_num_nxt;
      m4_pay_r <= m3_pay_r;
      m4_den_r <= m3_den_r;
      m4_num_r <= m3_num_r;
      m4_ovf_r <= m4_ovf_nxt;
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  logic                          dv_v_r    [spmg_pkg::DIV_N];
  spmg_pkg::pay_t                dv_pay_r  [spmg_pkg::DIV_N];
  logic [2:0]                    dv_ovf_r  [spmg_pkg::DIV_N];
  logic [spmg_pkg::DW-1:0]       dv_den_r  [spmg_pkg::DIV_N];
  logic [2:0][spmg_pkg::RW-1:0]  dv_rem_r  [spmg_pkg::DIV_N];
  logic [2:0][spmg_pkg::RW-1:0]  dv_rem_nxt[spmg_pkg::DIV_N];
  logic [2:0][spmg_pkg::QW-1:0]  dv_q_r    [spmg_pkg::DIV_N];
  logic [2:0][spmg_pkg::QW-1:0]  dv_q_nxt  [spmg_pkg::DIV_N];

  for (genvar i = 0; i < spmg_pkg::DIV_N; i++) begin : g_dv
    localparam int B = spmg_pkg::DIV_N - 1 - i;
    logic                          vin;
    spmg_pkg::pay_t                pin;
    logic [2:0]                    oin;
    logic [spmg_pkg::DW-1:0]       din;
    logic [2:0][spmg_pkg::RW-1:0]  rin;
    logic [2:0][spmg_pkg::QW-1:0]  qin;
    logic [spmg_pkg::RW-1:0]       trial;

    if (i == 0) begin : g_src
      assign vin = m4_v_r;
      assign pin = m4_pay_r;
      assign oin = m4_ovf_r;
      assign din = m4_den_r;
      assign rin = m4_num_r;
      assign qin = '0;
    end else begin : g_src
      assign vin = dv_v_r[i-1];
      assign pin = dv_pay_r[i-1];
      assign oin = dv_ovf_r[i-1];
      assign din = dv_den_r[i-1];
      assign rin = dv_rem_r[i-1];
      assign qin = dv_q_r[i-1];
    end

    assign trial = spmg_pkg::RW'(din) << B;

    always_comb begin
      dv_rem_nxt[i] = rin;
      dv_q_nxt[i]   = qin;
      for (int k = 0; k < 3; k++) begin
        if (rin[k] >= trial) begin
          dv_rem_nxt[i][k]  = rin[k] - trial;
          dv_q_nxt[i][k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i] <= 1'b0;
      end else if (adv) begin
        dv_v_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_pay_r[i] <= pin;
        dv_ovf_r[i] <= oin;
        dv_den_r[i] <= din;
        dv_rem_r[i] <= dv_rem_nxt[i];
        dv_q_r[i]   <= dv_q_nxt[i];
      end
    end
  end

  // clamp, sign, zeroing and output register
  localparam int DVL = spmg_pkg::DIV_N - 1;

  logic [2:0][47:0] acc_r, acc_nxt;
  logic             sat_r, sat_nxt;

  always_comb begin
    logic [spmg_pkg::QW:0] q;
    logic [spmg_pkg::QW:0] lim;
    logic                  rneg;
    sat_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      q    = dv_ovf_r[DVL][k] ? ((spmg_pkg::QW + 1)'(1) << spmg_pkg::QW)
                              : {1'b0, dv_q_r[DVL][k]};
      rneg = !dv_pay_r[DVL].neg[k] && dv_pay_r[DVL].nz[k];
      lim  = rneg ? ((spmg_pkg::QW + 1)'(1) << 47)
                  : (((spmg_pkg::QW + 1)'(1) << 47) - (spmg_pkg::QW + 1)'(1));
      if (q > lim) begin
        q       = lim;
        sat_nxt = 1'b1;
      end
      acc_nxt[k] = rneg ? (~q[47:0] + 48'd1) : q[47:0];
    end
    if (dv_pay_r[DVL].z || (mu_r == '0)) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[DVL];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_accel_x   = acc_r[0];
  assign out_accel_y   = acc_r[1];
  assign out_accel_z   = acc_r[2];
  assign out_saturated = sat_r;

endmodule

[sv/spmg_checker.sv]
module spmg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [47:0] in_offset_x,
  input logic signed [47:0] in_offset_y,
  input logic signed [47:0] in_offset_z,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_accel_x,
  input logic signed [47:0] out_accel_y,
  input logic signed [47:0] out_accel_z,
  input logic               out_saturated,
  input logic               cfg_we,
  input logic [0:0]         cfg_index,
  input logic [62:0]        cfg_data
);

  localparam logic [47:0] AMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] AMIN = 48'h8000_0000_0000;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accel_x)
      && $stable(out_accel_y) && $stable(out_accel_z) && $stable(out_saturated))
    else $error("held result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_accel_x == AMAX || out_accel_x == AMIN ||
      out_accel_y == AMAX || out_accel_y == AMIN ||
      out_accel_z == AMAX || out_accel_z == AMIN)
    else $error("saturated without a clamped component");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind softened_point_mass_gravity_unit spmg_checker u_spmg_checker (.*);
